### rtl/tspr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tspr_pkg
// shared constants, command and status types for the pixel renderer
// ---------------------------------------------------------------------------
package tspr_pkg;

  localparam int unsigned SpriteCountDef = 64;
  localparam int unsigned MemAddrBitsDef = 16;

  localparam logic [16:0] VisibleTicks = 17'd61440;
  localparam logic [16:0] FrameTicks   = 17'd81920;

  localparam logic [15:0] PalMapBase  = 16'h2E98;
  localparam logic [15:0] TileMapBase = 16'h3000;
  localparam logic [15:0] BgPalBase   = 16'h33C0;
  localparam logic [15:0] SpPalBase   = 16'h33E0;

  localparam logic [2:0] RegBgBase   = 3'd0;
  localparam logic [2:0] RegSpBase   = 3'd1;
  localparam logic [2:0] RegSpPage   = 3'd2;
  localparam logic [2:0] RegDefColor = 3'd3;
  localparam logic [2:0] RegScrollH  = 3'd4;
  localparam logic [2:0] RegScrollV  = 3'd5;

  // datapath operations: idle, clear, write, tick and the memory read steps
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_WRITE,
    OP_TICK,
    OP_PAL0,
    OP_PAL1,
    OP_TILE,
    OP_BGLO,
    OP_BGHI,
    OP_BGPAL,
    OP_SPX,
    OP_SPY,
    OP_SPCTL,
    OP_SPID,
    OP_SPLO,
    OP_SPHI
  } op_e;

  typedef struct packed {
    op_e op;
    logic [5:0] sprite;
  } cmd_t;

  typedef struct packed {
    logic blank;
    logic tile_zero;
    logic sp_hit;
    logic clear_done;
  } stat_t;

  function automatic logic [23:0] rgb_lookup(input logic [5:0] c);
    logic [23:0] t [64];
    t = '{24'h464646, 24'h00065a, 24'h000678, 24'h020673, 24'h35034c, 24'h57000e,
          24'h5a0000, 24'h410000, 24'h120200, 24'h001400, 24'h001e00, 24'h001e00,
          24'h001521, 24'h000000, 24'h000000, 24'h000000, 24'h9d9d9d, 24'h004ab9,
          24'h0530e1, 24'h5718da, 24'h9f07a7, 24'hcc0255, 24'hcf0b00, 24'ha42300,
          24'h5c3f00, 24'h0b5800, 24'h006600, 24'h006713, 24'h005e6e, 24'h000000,
          24'h000000, 24'h000000, 24'hfeffff, 24'h1f9eff, 24'h5376ff, 24'h9865ff,
          24'hfc67ff, 24'hff6cb3, 24'hff7466, 24'hff8014, 24'hc49a00, 24'h71b300,
          24'h28c421, 24'h00c874, 24'h00bfd0, 24'h2b2b2b, 24'h000000, 24'h000000,
          24'hfeffff, 24'h9ed5ff, 24'hafc0ff, 24'hd0b8ff, 24'hfebfff, 24'hffc0e0,
          24'hffc3bd, 24'hffca9c, 24'he7d58b, 24'hc5df8e, 24'ha6e6a3, 24'h94e8c5,
          24'h92e4eb, 24'ha7a7a7, 24'h000000, 24'h000000};
    return t[c];
  endfunction

endpackage

### rtl/tspr_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tspr_ctrl
// sequencer: clearing pass, writes, background fetch and sprite scan
// ---------------------------------------------------------------------------
module tspr_ctrl #(
  parameter int unsigned SpriteCount = tspr_pkg::SpriteCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_action_i,
  output logic            in_stall_o,
  input  logic            out_busy_i,
  output logic            out_load_o,
  input  tspr_pkg::stat_t stat_i,
  output tspr_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PAL0  = 4'd2;
  localparam logic [3:0] S_PAL1  = 4'd3;
  localparam logic [3:0] S_TILE  = 4'd4;
  localparam logic [3:0] S_BGLO  = 4'd5;
  localparam logic [3:0] S_BGHI  = 4'd6;
  localparam logic [3:0] S_BGPAL = 4'd7;
  localparam logic [3:0] S_SPX   = 4'd8;
  localparam logic [3:0] S_SPY   = 4'd9;
  localparam logic [3:0] S_SPCTL = 4'd10;
  localparam logic [3:0] S_SPID  = 4'd11;
  localparam logic [3:0] S_SPLO  = 4'd12;
  localparam logic [3:0] S_SPHI  = 4'd13;
  localparam logic [3:0] S_SPPAL = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  localparam logic [5:0] LastSprite = 6'(SpriteCount - 1);

  logic [3:0] state_q, state_d;
  logic [5:0] spr_q, spr_d;
  logic       take;

  assign in_stall_o = (state_q != S_IDLE) || (!in_action_i && out_busy_i);
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    spr_d      = spr_q;
    cmd_o.op   = tspr_pkg::OP_IDLE;
    cmd_o.sprite = spr_q;
    out_load_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = tspr_pkg::OP_CLEAR;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          if (in_action_i) begin
            cmd_o.op = tspr_pkg::OP_WRITE;
          end else begin
            cmd_o.op = tspr_pkg::OP_TICK;
            state_d  = S_PAL0;
          end
        end
      end
      S_PAL0: begin
        if (stat_i.blank) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = tspr_pkg::OP_PAL0;
          state_d  = S_PAL1;
        end
      end
      S_PAL1: begin
        cmd_o.op = tspr_pkg::OP_PAL1;
        state_d  = S_TILE;
      end
      S_TILE: begin
        cmd_o.op = tspr_pkg::OP_TILE;
        state_d  = S_BGLO;
      end
      S_BGLO: begin
        // tile byte is in the datapath now
        spr_d = '0;
        if (stat_i.tile_zero) begin
          state_d = S_SPX;
        end else begin
          cmd_o.op = tspr_pkg::OP_BGLO;
          state_d  = S_BGHI;
        end
      end
      S_BGHI: begin
        cmd_o.op = tspr_pkg::OP_BGHI;
        state_d  = S_BGPAL;
      end
      S_BGPAL: begin
        cmd_o.op = tspr_pkg::OP_BGPAL;
        state_d  = S_SPX;
      end
      S_SPX: begin
        cmd_o.op = tspr_pkg::OP_SPX;
        state_d  = S_SPY;
      end
      S_SPY: begin
        cmd_o.op = tspr_pkg::OP_SPY;
        state_d  = S_SPCTL;
      end
      S_SPCTL: begin
        cmd_o.op = tspr_pkg::OP_SPCTL;
        state_d  = S_SPID;
      end
      S_SPID: begin
        cmd_o.op = tspr_pkg::OP_SPID;
        state_d  = S_SPLO;
      end
      S_SPLO: begin
        if (stat_i.sp_hit) begin
          cmd_o.op = tspr_pkg::OP_SPLO;
          state_d  = S_SPHI;
        end else begin
          state_d = S_SPPAL;
        end
      end
      S_SPHI: begin
        cmd_o.op = tspr_pkg::OP_SPHI;
        state_d  = S_SPPAL;
      end
      S_SPPAL: begin
        // palette byte lands next cycle, taken only for an opaque texel
        if (spr_q == LastSprite) begin
          state_d = S_DONE;
        end else begin
          spr_d   = spr_q + 6'd1;
          state_d = S_SPX;
        end
      end
      S_DONE: begin
        out_load_o = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      spr_q   <= '0;
    end else begin
      state_q <= state_d;
      spr_q   <= spr_d;
    end
  end

endmodule

### rtl/tspr_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tspr_datapath
// video memory, frame counter, background and sprite colour pipeline
// ---------------------------------------------------------------------------
module tspr_datapath #(
  parameter int unsigned MemAddrBits = tspr_pkg::MemAddrBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tspr_pkg::cmd_t         cmd_i,
  output tspr_pkg::stat_t        stat_o,
  input  logic [MemAddrBits-1:0] wr_addr_i,
  input  logic [7:0]             wr_data_i,
  input  logic [15:0]            bg_base_i,
  input  logic [15:0]            sp_base_i,
  input  logic [2:0]             sp_page_i,
  input  logic [5:0]             def_color_i,
  input  logic [7:0]             scroll_h_i,
  input  logic [7:0]             scroll_v_i,
  output logic [7:0]             px_o,
  output logic [7:0]             py_o,
  output logic [5:0]             color_o,
  output logic                   blank_o
);

  localparam int unsigned Depth = 1 << MemAddrBits;

  logic [7:0] mem [Depth];
  logic [7:0] rd_q;
  logic [MemAddrBits-1:0] clr_q, rd_addr;
  logic clear_done_q;

  logic [16:0] tick_q, tick_nx;
  logic        blank_q;
  logic [7:0]  px, py, sxs, sys;
  logic [9:0]  map_idx;
  logic [11:0] pbit;
  logic [2:0]  pal_q;
  logic [7:0]  tile_q, lo_q;
  logic [5:0]  color_q;
  logic [7:0]  spx_q, spy_q, ctl_q, sid_q;
  logic [7:0]  tile_now, sid_now;
  logic [8:0]  spxe, spye;
  logic [2:0]  cx, cy;
  logic        hit;
  logic [1:0]  bg_t, sp_t;
  logic [15:0] bg_tb, sp_tb;
  logic [10:0] ent;
  tspr_pkg::op_e op_q;
  logic [2:0]  pb_lo_q;

  assign px   = tick_q[7:0];
  assign py   = tick_q[15:8];
  assign sxs  = px - scroll_h_i;
  assign sys  = py - scroll_v_i;
  assign map_idx = {sys[7:3], sxs[7:3]};
  assign pbit = {2'b00, map_idx} + {1'b0, map_idx, 1'b0};

  assign spxe = {1'b0, spx_q} + 9'd8;
  assign spye = {1'b0, spy_q} + 9'd8;
  assign hit  = ctl_q[0] && (px >= spx_q) && ({1'b0, px} < spxe) &&
                (py >= spy_q) && ({1'b0, py} < spye);
  assign cx   = ctl_q[1] ? ~(3'(px - spx_q)) : 3'(px - spx_q);
  assign cy   = ctl_q[2] ? ~(3'(py - spy_q)) : 3'(py - spy_q);

  // tile and sprite id bytes are still in the read register on their first use
  assign tile_now = (op_q == tspr_pkg::OP_TILE) ? rd_q : tile_q;
  assign sid_now  = (op_q == tspr_pkg::OP_SPID) ? rd_q : sid_q;

  assign bg_tb = bg_base_i + {4'b0, tile_now, 4'b0};
  assign sp_tb = sp_base_i + {4'b0, sid_now, 4'b0};
  assign ent   = {sp_page_i, 8'b0} + {3'b0, cmd_i.sprite, 2'b0};

  // plane high is the byte just read, low plane kept from the step before
  assign bg_t = {rd_q[3'd7 - sxs[2:0]], lo_q[3'd7 - sxs[2:0]]};
  assign sp_t = {rd_q[3'd7 - cx], lo_q[3'd7 - cx]};

  assign tick_nx = (tick_q == tspr_pkg::FrameTicks - 17'd1) ? '0 : tick_q + 17'd1;

  always_comb begin
    rd_addr = '0;
    unique case (cmd_i.op)
      tspr_pkg::OP_PAL0:  rd_addr = MemAddrBits'(tspr_pkg::PalMapBase + {7'b0, pbit[11:3]});
      tspr_pkg::OP_PAL1:  rd_addr = MemAddrBits'(tspr_pkg::PalMapBase + {7'b0, pbit[11:3]}
                                                 + 16'd1);
      tspr_pkg::OP_TILE:  rd_addr = MemAddrBits'(tspr_pkg::TileMapBase + {6'b0, map_idx});
      tspr_pkg::OP_BGLO:  rd_addr = MemAddrBits'(bg_tb + {13'b0, sys[2:0]});
      tspr_pkg::OP_BGHI:  rd_addr = MemAddrBits'(bg_tb + {13'b0, sys[2:0]} + 16'd8);
      tspr_pkg::OP_BGPAL: rd_addr = MemAddrBits'(tspr_pkg::BgPalBase +
                                    {11'b0, pal_q, bg_t});
      tspr_pkg::OP_SPX:   rd_addr = MemAddrBits'({5'b0, ent});
      tspr_pkg::OP_SPY:   rd_addr = MemAddrBits'({5'b0, ent + 11'd1});
      tspr_pkg::OP_SPCTL: rd_addr = MemAddrBits'({5'b0, ent + 11'd2});
      tspr_pkg::OP_SPID:  rd_addr = MemAddrBits'({5'b0, ent + 11'd3});
      tspr_pkg::OP_SPLO:  rd_addr = MemAddrBits'(sp_tb + {13'b0, cy});
      tspr_pkg::OP_SPHI:  rd_addr = MemAddrBits'(sp_tb + {13'b0, cy} + 16'd8);
      default:            rd_addr = '0;
    endcase
  end

  // the palette read for a sprite is issued in the cycle after its high plane read
  logic [MemAddrBits-1:0] sppal_addr;
  assign sppal_addr = MemAddrBits'(tspr_pkg::SpPalBase + {11'b0, ctl_q[5:3], sp_t});

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tspr_pkg::OP_CLEAR) begin
      mem[clr_q] <= 8'h00;
    end else if (cmd_i.op == tspr_pkg::OP_WRITE) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= (op_q == tspr_pkg::OP_SPHI) ? mem[sppal_addr] : mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      clear_done_q <= 1'b0;
      tick_q       <= '0;
      blank_q      <= 1'b0;
      op_q         <= tspr_pkg::OP_IDLE;
    end else begin
      op_q <= cmd_i.op;
      if (cmd_i.op == tspr_pkg::OP_CLEAR) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == '1) clear_done_q <= 1'b1;
      end
      if (cmd_i.op == tspr_pkg::OP_TICK) begin
        tick_q  <= tick_nx;
        blank_q <= tick_nx >= tspr_pkg::VisibleTicks;
      end
    end
  end

  // sprite palette landing
  logic sp_pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_pend_q <= 1'b0;
    end else begin
      sp_pend_q <= 1'b0;
      if (op_q == tspr_pkg::OP_SPHI) begin
        sp_pend_q <= sp_t != 2'b00;
      end
    end
  end

  // capture what the read steps returned
  always_ff @(posedge clk_i) begin
    unique case (op_q)
      tspr_pkg::OP_PAL0: pb_lo_q <= pbit[2:0];
      default: ;
    endcase
    unique case (op_q)
      tspr_pkg::OP_PAL0: lo_q <= rd_q;
      tspr_pkg::OP_PAL1: begin
        pal_q <= 3'(({lo_q, rd_q} << pb_lo_q) >> 13);
      end
      tspr_pkg::OP_TILE: begin
        tile_q  <= rd_q;
        color_q <= def_color_i;
      end
      tspr_pkg::OP_BGLO: lo_q <= rd_q;
      tspr_pkg::OP_BGPAL: color_q <= rd_q[5:0];
      tspr_pkg::OP_SPX:   spx_q <= rd_q;
      tspr_pkg::OP_SPY:   spy_q <= rd_q;
      tspr_pkg::OP_SPCTL: ctl_q <= rd_q;
      tspr_pkg::OP_SPID:  sid_q <= rd_q;
      tspr_pkg::OP_SPLO:  lo_q <= rd_q;
      tspr_pkg::OP_SPHI:  lo_q <= lo_q;
      default: ;
    endcase
    if (sp_pend_q) color_q <= rd_q[5:0];
  end

  assign stat_o.blank      = blank_q;
  assign stat_o.tile_zero  = rd_q == 8'h00;
  assign stat_o.sp_hit     = hit;
  assign stat_o.clear_done = clear_done_q;

  assign px_o    = px;
  assign py_o    = py;
  // last sprite's colour is still landing when the result is loaded
  assign color_o = sp_pend_q ? rd_q[5:0] : color_q;
  assign blank_o = blank_q;

endmodule

### rtl/tile_sprite_pixel_renderer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tile_sprite_pixel_renderer
// tile and sprite pixel renderer over a 64 KiB video store
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): a beat is either a video memory
// write (action 1) or a pixel tick (action 0). A write gives no result. A
// tick gives one result beat on the output channel (out_valid_o /
// out_stall_i) with the pixel or a blanking marker. A blanking tick reads
// no bytes. A visible tick reads the two palette map bytes, the tile byte,
// then the two background planes and background palette byte unless the
// tile is zero, then for each sprite its X, Y, control and id bytes, plus
// its two planes and a palette byte if it covers the pixel, all through the
// single read port of the video store. Results sit in an output register;
// a new write beat is accepted while it waits, a new tick only once it has
// been taken. A stall simply holds it. After reset a clearing pass zeroes
// the store, one byte per cycle, with no beat accepted; configuration
// writes are taken throughout via cfg_valid_i / cfg_ready_o.
// ---------------------------------------------------------------------------
module tile_sprite_pixel_renderer #(
  parameter int unsigned SpriteCount = tspr_pkg::SpriteCountDef,
  parameter int unsigned MemAddrBits = tspr_pkg::MemAddrBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [MemAddrBits-1:0] address_i,
  input  logic [7:0]             data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   pixel_valid_o,
  output logic [7:0]             pixel_x_o,
  output logic [7:0]             pixel_y_o,
  output logic [5:0]             color_index_o,
  output logic [23:0]            pixel_rgb_o,
  output logic                   in_vblank_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i
);

  tspr_pkg::cmd_t  cmd;
  tspr_pkg::stat_t stat;
  logic out_load;
  logic [7:0] px, py;
  logic [5:0] color;
  logic blank;

  logic [15:0] bg_base_q, sp_base_q;
  logic [2:0]  sp_page_q;
  logic [5:0]  def_color_q;
  logic [7:0]  scroll_h_q, scroll_v_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_base_q   <= '0;
      sp_base_q   <= '0;
      sp_page_q   <= 3'd3;
      def_color_q <= 6'd63;
      scroll_h_q  <= '0;
      scroll_v_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tspr_pkg::RegBgBase:   bg_base_q   <= cfg_data_i;
        tspr_pkg::RegSpBase:   sp_base_q   <= cfg_data_i;
        tspr_pkg::RegSpPage:   sp_page_q   <= cfg_data_i[2:0];
        tspr_pkg::RegDefColor: def_color_q <= cfg_data_i[5:0];
        tspr_pkg::RegScrollH:  scroll_h_q  <= cfg_data_i[7:0];
        tspr_pkg::RegScrollV:  scroll_v_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  tspr_ctrl #(.SpriteCount(SpriteCount)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_action_i(action_i),
    .in_stall_o (in_stall_o),
    .out_busy_i (out_valid_o),
    .out_load_o (out_load),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tspr_datapath #(.MemAddrBits(MemAddrBits)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .wr_addr_i  (address_i),
    .wr_data_i  (data_i),
    .bg_base_i  (bg_base_q),
    .sp_base_i  (sp_base_q),
    .sp_page_i  (sp_page_q),
    .def_color_i(def_color_q),
    .scroll_h_i (scroll_h_q),
    .scroll_v_i (scroll_v_q),
    .px_o       (px),
    .py_o       (py),
    .color_o    (color),
    .blank_o    (blank)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_valid_o <= !blank;
      pixel_x_o     <= blank ? 8'd0 : px;
      pixel_y_o     <= blank ? 8'd0 : py;
      color_index_o <= blank ? 6'd0 : color;
      pixel_rgb_o   <= blank ? 24'd0 : tspr_pkg::rgb_lookup(color);
      in_vblank_o   <= blank;
    end
  end

`ifndef SYNTHESIS
  a_no_load_over_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while pending");
  a_vblank_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_vblank_o) |-> (!pixel_valid_o && color_index_o == 6'd0))
    else $error("blanking beat carries pixel data");
  a_visible_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pixel_valid_o) |-> (pixel_y_o < 8'd240))
    else $error("pixel row out of range");
`endif

endmodule
